### rtl/mrfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrfb_pkg
// Types, command codes and frame tables for the meter request frame builder.
// ----------------------------------------------------------------------------
package mrfb_pkg;

	localparam logic [2:0] CMD_HANDSHAKE = 3'd0;
	localparam logic [2:0] CMD_PASSWORD  = 3'd1;
	localparam logic [2:0] CMD_CLASS0    = 3'd2;
	localparam logic [2:0] CMD_CLASS2    = 3'd3;
	localparam logic [2:0] CMD_CLASS9    = 3'd4;
	localparam logic [2:0] CMD_CLASS11   = 3'd5;
	localparam logic [2:0] CMD_NEXT      = 3'd6;
	localparam logic [2:0] CMD_CLOSE     = 3'd7;

	localparam logic [15:0] CRC_POLY    = 16'h1021;
	localparam logic [31:0] KEY_OFFSET  = 32'h0000ab41;

	typedef struct packed {
		logic [2:0]  command;
		logic [15:0] meter_address;
		logic [31:0] session_key;
	} req_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} rsp_t;

	typedef struct packed {
		logic busy;
		logic done;
	} scr_stat_t;

	function automatic logic [3:0] frame_len(input logic [2:0] cmd);
		case (cmd)
			CMD_HANDSHAKE: frame_len = 4'd8;
			CMD_PASSWORD:  frame_len = 4'd11;
			CMD_NEXT,
			CMD_CLOSE:     frame_len = 4'd4;
			default:       frame_len = 4'd10;
		endcase
	endfunction

	function automatic logic crc_frame(input logic [2:0] cmd);
		crc_frame = (cmd == CMD_HANDSHAKE) || (cmd == CMD_PASSWORD);
	endfunction

	// Fixed bytes of every frame; variable positions read as zero here.
	function automatic logic [7:0] fixed_byte(input logic [2:0] cmd, input logic [3:0] idx);
		logic [7:0] b;
		b = 8'h00;
		if (idx == 4'd0) begin
			b = 8'h02;
		end else begin
			case (cmd)
				CMD_HANDSHAKE, CMD_PASSWORD: begin
					case (idx)
						4'd1:    b = 8'h18;
						4'd2:    b = (cmd == CMD_HANDSHAKE) ? 8'h06 : 8'h01;
						4'd4:    b = (cmd == CMD_HANDSHAKE) ? 8'h01 : 8'h04;
						default: b = 8'h00;
					endcase
				end
				CMD_CLASS0: begin
					case (idx)
						4'd1:    b = 8'h05;
						4'd8:    b = 8'hF6;
						4'd9:    b = 8'h01;
						default: b = 8'h00;
					endcase
				end
				CMD_CLASS2: begin
					case (idx)
						4'd1:    b = 8'h05;
						4'd4:    b = 8'h28;
						4'd6:    b = 8'h32;
						4'd7:    b = 8'h02;
						4'd8:    b = 8'h07;
						4'd9:    b = 8'h39;
						default: b = 8'h00;
					endcase
				end
				CMD_CLASS9: begin
					case (idx)
						4'd1:    b = 8'h05;
						4'd7:    b = 8'h09;
						4'd8:    b = 8'h67;
						4'd9:    b = 8'h28;
						default: b = 8'h00;
					endcase
				end
				CMD_CLASS11: begin
					case (idx)
						4'd1:    b = 8'h05;
						4'd7:    b = 8'h0B;
						4'd8:    b = 8'h47;
						4'd9:    b = 8'h6A;
						default: b = 8'h00;
					endcase
				end
				CMD_NEXT: begin
					case (idx)
						4'd1:    b = 8'h81;
						4'd2:    b = 8'hE7;
						4'd3:    b = 8'hCB;
						default: b = 8'h00;
					endcase
				end
				default: begin
					case (idx)
						4'd1:    b = 8'h80;
						4'd2:    b = 8'hF7;
						4'd3:    b = 8'hEA;
						default: b = 8'h00;
					endcase
				end
			endcase
		end
		fixed_byte = b;
	endfunction

endpackage

### rtl/meter_request_frame_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meter_request_frame_builder
// Builds one meter request frame per command and sends it byte by byte.
//
// Request channel (req_valid / req_stall / req) carries one command beat.
// Response channel (rsp_valid / rsp_stall / rsp) carries one byte per beat,
// last_byte set on the final byte of the frame.
// cfg_wr_en / cfg_wr_data write the remote password; write only when idle.
// req_stall is high from the accepted beat until the last byte has been
// loaded into the output register, so one command is worked at a time.
// Fixed and handshake frames (4 to 10 bytes) load one byte per cycle into
// the output register unless the receiver stalls. Password frame: setup,
// then 1 to 16 scrambler rounds, one per cycle, before 11 bytes. The CRC
// unit folds handshake and password bytes one per cycle as they load.
// A stalled receiver holds the output byte and pauses the sequencer.
// Reset clears the password to zero and drops all pending beats.
// ----------------------------------------------------------------------------
module meter_request_frame_builder import mrfb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCR  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]  state_q;
	logic [31:0] passwd_q;
	logic [2:0]  cmd_q;
	logic [7:0]  addr_q;
	logic [31:0] pw_q;
	logic [3:0]  idx_q;
	logic        rsp_valid_q;
	rsp_t        rsp_q;

	logic        accept;
	logic        load;
	logic [3:0]  len;
	logic        is_last;
	logic        crc_upd;
	logic [7:0]  byte_nx;
	logic [10:0] addr_sum;
	logic [15:0] crc;
	scr_stat_t   scr_stat;
	logic [31:0] scr_pw;

	assign accept  = req_valid && !req_stall;
	assign load    = (state_q == ST_EMIT) && (!rsp_valid_q || !rsp_stall);
	assign len     = frame_len(cmd_q);
	assign is_last = (idx_q == len - 4'd1);
	assign crc_upd = load && crc_frame(cmd_q) && (idx_q < len - 4'd2);

	assign addr_sum = {7'd0, req.meter_address[3:0]} * 11'd100
		+ {7'd0, req.meter_address[15:12]} * 11'd10
		+ {7'd0, req.meter_address[11:8]};

	always_comb begin
		byte_nx = fixed_byte(cmd_q, idx_q);
		if (cmd_q == CMD_HANDSHAKE) begin
			case (idx_q)
				4'd5:    byte_nx = addr_q;
				4'd6:    byte_nx = crc[15:8];
				4'd7:    byte_nx = crc[7:0];
				default: byte_nx = fixed_byte(cmd_q, idx_q);
			endcase
		end else if (cmd_q == CMD_PASSWORD) begin
			case (idx_q)
				4'd5:    byte_nx = pw_q[31:24];
				4'd6:    byte_nx = pw_q[23:16];
				4'd7:    byte_nx = pw_q[15:8];
				4'd8:    byte_nx = pw_q[7:0];
				4'd9:    byte_nx = crc[15:8];
				4'd10:   byte_nx = crc[7:0];
				default: byte_nx = fixed_byte(cmd_q, idx_q);
			endcase
		end
	end

	mrfb_scrambler u_scr (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && (req.command == CMD_PASSWORD)),
		.key      (req.session_key),
		.password (passwd_q),
		.stat     (scr_stat),
		.result   (scr_pw)
	);

	mrfb_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (accept),
		.update (crc_upd),
		.data   (byte_nx),
		.crc    (crc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			passwd_q <= 32'h0000_0000;
		end else if (cfg_wr_en) begin
			passwd_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			idx_q       <= 4'd0;
		end else begin
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q   <= 4'd0;
						state_q <= (req.command == CMD_PASSWORD) ? ST_SCR : ST_EMIT;
					end
				end
				ST_SCR: begin
					if (scr_stat.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load) begin
						idx_q <= idx_q + 4'd1;
						if (is_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= req.command;
			addr_q <= addr_sum[7:0];
		end
		if ((state_q == ST_SCR) && scr_stat.done && !scr_stat.busy) begin
			pw_q <= scr_pw;
		end
		if (load) begin
			rsp_q.frame_byte <= byte_nx;
			rsp_q.last_byte  <= is_last;
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### rtl/mrfb_crc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrfb_crc
// CRC-16 accumulator, poly 0x1021, init 0, one byte per cycle while update is high.
// ----------------------------------------------------------------------------
module mrfb_crc import mrfb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        clear,
	input  logic        update,
	input  logic [7:0]  data,
	output logic [15:0] crc
);

	logic [15:0] crc_q;
	logic [15:0] crc_nx;

	always_comb begin
		crc_nx = crc_q ^ {data, 8'h00};
		for (int b = 0; b < 8; b++) begin
			if (crc_nx[15]) begin
				crc_nx = {crc_nx[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				crc_nx = {crc_nx[14:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= 16'h0000;
		end else if (clear) begin
			crc_q <= 16'h0000;
		end else if (update) begin
			crc_q <= crc_nx;
		end
	end

	assign crc = crc_q;

endmodule

### rtl/mrfb_scrambler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrfb_scrambler
// Password scrambler: one rotate-and-xor round per cycle, 1 to 16 rounds.
// ----------------------------------------------------------------------------
module mrfb_scrambler import mrfb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] key,
	input  logic [31:0] password,
	output scr_stat_t   stat,
	output logic [31:0] result
);

	logic [31:0] k_q;
	logic [31:0] pw_q;
	logic        carry_q;
	logic [3:0]  cnt_q;
	logic        setup_q;
	logic        run_q;
	logic        done_q;
	logic [31:0] k_nx;
	logic [3:0]  round_cnt;

	assign k_nx      = {k_q[30:0], carry_q};
	assign round_cnt = k_q[3:0] + k_q[11:8] + k_q[19:16] + k_q[27:24];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setup_q <= 1'b0;
			run_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				setup_q <= 1'b1;
			end else if (setup_q) begin
				setup_q <= 1'b0;
				run_q   <= 1'b1;
			end else if (run_q) begin
				if (cnt_q == 4'd0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			k_q     <= key + KEY_OFFSET;
			pw_q    <= password;
			carry_q <= 1'b0;
		end else if (setup_q) begin
			cnt_q <= round_cnt;
		end else if (run_q) begin
			k_q     <= k_nx;
			carry_q <= k_q[31];
			pw_q    <= pw_q ^ k_nx;
			cnt_q   <= cnt_q - 4'd1;
		end
	end

	assign stat.busy = setup_q || run_q;
	assign stat.done = done_q;
	assign result    = pw_q;

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Sends command beats to the meter request frame builder and checks every
// frame byte against a predictor that builds each frame, its address byte,
// scrambled password and CRC. Directed commands come first, then random
// commands under several password settings, with random idling on both
// channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
	import mrfb_pkg::*;

	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned HOLD_AFTER  = 400;
	localparam int unsigned SEG_ITEMS   = 16;

	typedef struct {
		req_t        beat;
		int unsigned len;
		logic [87:0] golden;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = '0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_t        req = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp;

	logic [31:0] password_copy = '0;
	rsp_t        due_bytes [$];
	dir_row_t    directed_rows [$];
	rsp_t        head_byte;

	int unsigned sender_idle_pct = 37;
	int unsigned receiver_idle_pct = 52;
	int unsigned mismatches = 0;
	int unsigned bytes_seen = 0;
	int unsigned beats_sent = 0;
	int unsigned hs_frames = 0;
	int unsigned pw_frames = 0;
	int unsigned settings_used = 1;
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;

	meter_request_frame_builder u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [15:0] crc_fold(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++)
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		return c;
	endfunction

	function automatic logic [31:0] scramble_pw(input logic [31:0] key, input logic [31:0] pw);
		logic [31:0] k;
		logic [31:0] p;
		logic [7:0]  sum;
		logic        carry;
		logic        top;
		int          rounds;
		k = key + KEY_OFFSET;
		sum = k[7:0] + k[15:8] + k[23:16] + k[31:24];
		rounds = int'(sum[3:0]) + 1;
		carry = 1'b0;
		p = pw;
		for (int r = 0; r < rounds; r++) begin
			top = k[31];
			k = (k << 1) + {31'd0, carry};
			carry = top;
			p ^= k;
		end
		return p;
	endfunction

	task automatic queue_frame(input req_t b);
		logic [79:0] fixed;
		logic [7:0]  fb [11];
		logic [15:0] crc;
		logic [31:0] p;
		rsp_t        r;
		int          n;
		int          a;
		case (b.command)
			CMD_HANDSHAKE: begin fixed = {48'h0218_0600_0100, 32'h0}; n = 8; end
			CMD_PASSWORD:  begin fixed = {40'h02_1801_0004, 40'h0}; n = 11; end
			CMD_CLASS0:    begin fixed = 80'h0205_0000_0000_0000_F601; n = 10; end
			CMD_CLASS2:    begin fixed = 80'h0205_0000_2800_3202_0739; n = 10; end
			CMD_CLASS9:    begin fixed = 80'h0205_0000_0000_0009_6728; n = 10; end
			CMD_CLASS11:   begin fixed = 80'h0205_0000_0000_000B_476A; n = 10; end
			CMD_NEXT:      begin fixed = {32'h0281_E7CB, 48'h0}; n = 4; end
			default:       begin fixed = {32'h0280_F7EA, 48'h0}; n = 4; end
		endcase
		for (int i = 0; i < 11; i++)
			fb[i] = (i < 10) ? fixed[79 - 8 * i -: 8] : 8'h00;
		if (b.command == CMD_HANDSHAKE) begin
			a = int'(b.meter_address[3:0]) * 100 + int'(b.meter_address[15:12]) * 10
				+ int'(b.meter_address[11:8]);
			fb[5] = a[7:0];
		end
		if (b.command == CMD_PASSWORD) begin
			p = scramble_pw(b.session_key, password_copy);
			{fb[5], fb[6], fb[7], fb[8]} = p;
		end
		if (b.command == CMD_HANDSHAKE || b.command == CMD_PASSWORD) begin
			crc = 16'h0000;
			for (int i = 0; i < n - 2; i++)
				crc = crc_fold(crc, fb[i]);
			fb[n - 2] = crc[15:8];
			fb[n - 1] = crc[7:0];
		end
		for (int i = 0; i < n; i++) begin
			r.frame_byte = fb[i];
			r.last_byte = (i == n - 1);
			due_bytes.push_back(r);
		end
	endtask

	function automatic req_t random_beat();
		req_t b;
		int   pick;
		pick = $urandom_range(99);
		if (pick < 30)
			b.command = CMD_PASSWORD;
		else if (pick < 50)
			b.command = CMD_HANDSHAKE;
		else
			b.command = 3'($urandom_range(7));
		b.meter_address = 16'($urandom_range(16'hFFFF));
		case ($urandom_range(3))
			0:       b.session_key = 32'hFFFF_54BF + $urandom_range(31);
			1:       b.session_key = 32'h7FFF_54BF + $urandom_range(31);
			default: b.session_key = $urandom;
		endcase
		return b;
	endfunction

	function automatic void add_row(input logic [2:0] cmd, input logic [15:0] addr,
			input logic [31:0] key, input int unsigned len, input logic [87:0] golden);
		dir_row_t row;
		row.beat.command = cmd;
		row.beat.meter_address = addr;
		row.beat.session_key = key;
		row.len = len;
		row.golden = golden;
		directed_rows.push_back(row);
	endfunction

	task automatic send_beat(input req_t b, input int unsigned len, input logic [87:0] golden);
		rsp_t r;
		while ($urandom_range(99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			req <= random_beat();
			@(posedge clk);
		end
		req <= b;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		beats_sent++;
		if (b.command == CMD_HANDSHAKE)
			hs_frames++;
		if (b.command == CMD_PASSWORD)
			pw_frames++;
		if (len > 0) begin
			for (int i = 0; i < len; i++) begin
				r.frame_byte = golden[87 - 8 * i -: 8];
				r.last_byte = (i == len - 1);
				due_bytes.push_back(r);
			end
		end else begin
			queue_frame(b);
		end
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (due_bytes.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic set_password(input logic [31:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		password_copy = value;
		settings_used++;
	endtask

	task automatic note_mismatch(input string what, input rsp_t want, input rsp_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch (%s) at %0t: expected byte %02h last %0b, got byte %02h last %0b",
				what, $time, want.frame_byte, want.last_byte, got.frame_byte, got.last_byte);
	endtask

	// hold off the receiver once, long enough to back up the request side
	always @(posedge clk) begin
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!hold_done && bytes_seen >= HOLD_AFTER) begin
			rsp_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			bytes_seen <= bytes_seen + 1;
			if (due_bytes.size() == 0) begin
				note_mismatch("unexpected beat", '0, rsp);
			end else begin
				head_byte = due_bytes.pop_front();
				if (head_byte.frame_byte !== rsp.frame_byte || head_byte.last_byte !== rsp.last_byte)
					note_mismatch("wrong field", head_byte, rsp);
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
		$display("FAIL");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row(CMD_CLOSE,     16'h0000, 32'h0000_0000, 4, {32'h0280_F7EA, 56'h0});
		add_row(CMD_NEXT,      16'hFFFF, 32'hFFFF_FFFF, 4, {32'h0281_E7CB, 56'h0});
		add_row(CMD_CLASS0,    16'hFFFF, 32'hFFFF_FFFF, 10, {80'h0205_0000_0000_0000_F601, 8'h0});
		add_row(CMD_CLASS2,    16'h0000, 32'h0000_0000, 10, {80'h0205_0000_2800_3202_0739, 8'h0});
		add_row(CMD_CLASS9,    16'hA5A5, 32'h5A5A_5A5A, 10, {80'h0205_0000_0000_0009_6728, 8'h0});
		add_row(CMD_CLASS11,   16'h5A5A, 32'hA5A5_A5A5, 10, {80'h0205_0000_0000_000B_476A, 8'h0});
		add_row(CMD_HANDSHAKE, 16'h0000, 32'h0000_0000, 0, '0);
		add_row(CMD_HANDSHAKE, 16'hFFFF, 32'hFFFF_FFFF, 0, '0);
		add_row(CMD_HANDSHAKE, 16'h9999, 32'h0000_0000, 0, '0);
		add_row(CMD_HANDSHAKE, 16'h1234, 32'h0000_0000, 0, '0);
		add_row(CMD_HANDSHAKE, 16'hF00F, 32'h0000_0000, 0, '0);
		add_row(CMD_HANDSHAKE, 16'h0A0A, 32'h0000_0000, 0, '0);
		add_row(CMD_PASSWORD,  16'h0000, 32'h0000_0000, 0, '0);
		add_row(CMD_PASSWORD,  16'hFFFF, 32'hFFFF_FFFF, 0, '0);
		add_row(CMD_PASSWORD,  16'h0000, 32'hFFFF_54BF, 0, '0);
		add_row(CMD_PASSWORD,  16'h0000, 32'hFFFF_54CE, 0, '0);
		add_row(CMD_PASSWORD,  16'h0000, 32'h7FFF_54CE, 0, '0);
		add_row(CMD_PASSWORD,  16'h0000, 32'h1234_5678, 0, '0);
		add_row(CMD_CLOSE,     16'hFFFF, 32'hFFFF_FFFF, 4, {32'h0280_F7EA, 56'h0});

		foreach (directed_rows[i])
			send_beat(directed_rows[i].beat, directed_rows[i].len, directed_rows[i].golden);

		for (int seg = 0; seg < 6; seg++) begin
			drain();
			case (seg)
				0:       set_password(32'hFFFF_FFFF);
				2:       set_password(32'h0000_0000);
				4:       set_password(32'h8000_0001);
				default: set_password($urandom);
			endcase
			if (seg == 2) begin
				sender_idle_pct = 52;
				receiver_idle_pct = 37;
			end else if (seg == 4) begin
				sender_idle_pct = 0;
				receiver_idle_pct = 0;
			end
			repeat (SEG_ITEMS) send_beat(random_beat(), 0, '0);
		end

		drain();
		repeat (40) @(posedge clk);
		if (due_bytes.size() != 0) begin
			mismatches += due_bytes.size();
			$display("%0d expected frame bytes never arrived", due_bytes.size());
		end

		$display("covered %0d commands (%0d handshake, %0d password) and %0d frame bytes",
			beats_sent, hs_frames, pw_frames, bytes_seen);
		$display("over %0d password settings, three idling mixes and a %0d-cycle receiver hold",
			settings_used, HOLD_CYCLES);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### filelist.f
rtl/mrfb_pkg.sv
rtl/mrfb_crc.sv
rtl/mrfb_scrambler.sv
rtl/meter_request_frame_builder.sv
test/testbench.sv
